### src/szdd_pkg.sv
// Shared types and constants for the SZDD/LZSS decompressor.
// No dependencies; imported by szdd_lzss_decompressor.
`default_nettype none

package szdd_pkg;

    // Header layout
    localparam logic [3:0] MAGIC_LEN     = 4'd9;   // 8 magic bytes plus compression type
    localparam logic [3:0] LEN_FIELD_POS = 4'd10;  // first byte of the length field
    localparam logic [3:0] HDR_LEN       = 4'd14;

    // Window fill value and output inversion mask
    localparam logic [7:0] FILL_BYTE   = 8'h20;
    localparam logic [7:0] INVERT_MASK = 8'hFF;

    // Flag byte handling
    localparam logic [7:0]  FLAG_MARK  = 8'hFF;
    localparam int          FLAG_VALID = 8;

    // Back-reference fields
    localparam int         CNT_W    = 5;
    localparam logic [4:0] MIN_COPY = 5'd3;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_COPY = 2'b10
    } state_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       status;
        logic       last_of_run;
        logic       end_of_output;
    } out_item_t;

    // Expected header byte at positions 0 to 8
    function automatic logic [7:0] magic_byte(input logic [3:0] pos);
        logic [7:0] val;
        case (pos)
            4'd0: val = 8'h53;
            4'd1: val = 8'h5A;
            4'd2: val = 8'h44;
            4'd3: val = 8'h44;
            4'd4: val = 8'h88;
            4'd5: val = 8'hF0;
            4'd6: val = 8'h27;
            4'd7: val = 8'h33;
            4'd8: val = 8'h41;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

### src/szdd_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module szdd_ram #(
    parameter int DATA_WIDTH = 8,
    parameter int DEPTH      = 4096,
    parameter int ADDR_WIDTH = $clog2(DEPTH)
) (
    input  wire logic                  clk,
    input  wire logic                  wr_en,
    input  wire logic [ADDR_WIDTH-1:0] wr_addr,
    input  wire logic [DATA_WIDTH-1:0] wr_data,
    input  wire logic [ADDR_WIDTH-1:0] rd_addr,
    output logic      [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### src/szdd_lzss_decompressor.sv
// SZDD / LZSS decompressor: header check, length field, LZSS body decode.
// Depends on szdd_pkg and szdd_ram (history window).
//
// Usage: file bytes enter on the s_ request channel (s_valid/s_ready), one
// byte per request; s_start_of_file on the first header byte restarts the
// decoder. Decoded bytes leave on the m_ channel (m_valid/m_ready), with a
// status flag, a last-of-run flag for the final byte caused by one request
// and an end-of-output flag on the byte that reaches the declared length.
// cfg_wr_en/cfg_wr_data set the number of leading bytes inverted; write it
// only while the block is idle.
// Header, flag, first-of-pair and literal bytes are handled as accepted; the
// second byte of a back-reference starts a copy of L bytes (3 to 18, cut at
// the declared length) and s_ready stays low until it ends. The window RAM
// read port moves one byte per cycle while the queue has room, forwarding
// when a copy reads the byte just written; m_ is driven from a register.
// Reset clears all control state and the window fill count, so the window
// reads as 0x20 at once; no clearing pass. A restart also clears the fill count.
// When the receiver stalls, a two-entry output queue fills and the copy and
// then s_ready hold until space returns; nothing is dropped.
`default_nettype none

module szdd_lzss_decompressor #(
    parameter int WINDOW_BITS = 12,
    parameter int LENGTH_BITS = 32
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // file byte requests
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_byte_value,
    input  wire logic       s_start_of_file,
    // decoded byte requests
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_status,
    output logic            m_last_of_run,
    output logic            m_end_of_output,
    // configuration
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data
);

    import szdd_pkg::*;

    localparam int W = WINDOW_BITS;
    localparam int L = LENGTH_BITS;
    localparam logic [W-1:0] INIT_PTR  = W'((1 << W) - 16);
    localparam logic [W:0]   FILL_FULL = {1'b1, {W{1'b0}}};

    // Control and decode state
    state_t                 state_reg, state_next;
    logic [3:0]             hdr_pos_reg, hdr_pos_next;
    logic                   rejected_reg, rejected_next;
    logic [L-1:0]           declared_reg, declared_next;
    logic [L-1:0]           emitted_reg, emitted_next;
    logic [15:0]            flags_reg, flags_next;
    logic [7:0]             pair_first_reg, pair_first_next;
    logic                   await_reg, await_next;
    logic [W-1:0]           wp_reg, wp_next;
    logic [W:0]             fill_reg, fill_next;
    logic [7:0]             xor_len_reg;

    // Copy engine
    logic [W-1:0]           rd_addr_reg, rd_addr_next;
    logic [CNT_W-1:0]       rd_cnt_reg, rd_cnt_next;
    logic                   rd_pending_reg, rd_pending_next;
    logic                   rd_fill_ok_reg, rd_fill_ok_next;
    logic                   rd_fwd_reg, rd_fwd_next;
    logic [7:0]             fwd_data_reg, fwd_data_next;
    logic                   rd_last_reg, rd_last_next;

    // Output queue
    out_item_t              out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;
    out_item_t              pend_reg, pend_next;
    logic                   pend_valid_reg, pend_valid_next;

    // Window RAM
    logic                   win_we;
    logic [7:0]             win_wdata;
    logic [7:0]             win_rdata;

    // Datapath helpers
    logic                   accept;
    logic                   pop;
    logic                   arrival;
    logic [7:0]             arr_byte;
    logic                   issue;
    logic [1:0]             occ_after;
    logic                   emit;
    logic [7:0]             emit_raw;
    logic                   emit_last;
    logic                   push;
    out_item_t              push_item;
    logic [L-1:0]           emitted_plus1;
    logic [L-1:0]           remaining;
    logic [CNT_W-1:0]       ref_len;
    logic [W-1:0]           ref_pos;
    logic [11:0]            ref_pos_raw;
    logic [1:0]             lane;
    logic [31:0]            lane_val;
    logic [W-1:0]           rd_offset;
    logic [3:0]             hdr_eff;

    assign accept  = s_valid && s_ready;
    assign pop     = out_valid_reg && m_ready;
    assign arrival = rd_pending_reg;

    // Byte returned by the copy: forwarded, stored, or the fill value
    assign arr_byte = rd_fwd_reg ? fwd_data_reg : (rd_fill_ok_reg ? win_rdata : FILL_BYTE);

    // Hold new requests while a copy is running or the queue is not empty enough
    assign s_ready = (state_reg == ST_IDLE) && !rd_pending_reg && !pend_valid_reg;

    // Queue credit: a read issued now lands next cycle
    assign occ_after = 2'(out_valid_reg) + 2'(pend_valid_reg) + 2'(rd_pending_reg) - 2'(pop);
    assign issue     = (state_reg == ST_COPY) && (occ_after <= 2'd1);

    assign emitted_plus1 = emitted_reg + L'(1);
    assign remaining     = declared_reg - emitted_reg;
    assign ref_len       = {1'b0, s_byte_value[3:0]} + MIN_COPY;
    assign ref_pos_raw   = {s_byte_value[7:4], pair_first_reg};
    assign ref_pos       = W'(ref_pos_raw);
    assign hdr_eff       = s_start_of_file ? 4'd0 : hdr_pos_reg;
    assign lane          = 2'(hdr_eff - LEN_FIELD_POS);
    assign lane_val      = 32'(s_byte_value) << {lane, 3'b000};
    assign rd_offset     = rd_addr_reg - INIT_PTR;

    // Decode, copy issue and emission
    always_comb begin
        state_next      = state_reg;
        hdr_pos_next    = hdr_pos_reg;
        rejected_next   = rejected_reg;
        declared_next   = declared_reg;
        emitted_next    = emitted_reg;
        flags_next      = flags_reg;
        pair_first_next = pair_first_reg;
        await_next      = await_reg;
        wp_next         = wp_reg;
        fill_next       = fill_reg;
        rd_addr_next    = rd_addr_reg;
        rd_cnt_next     = rd_cnt_reg;
        rd_pending_next = 1'b0;
        rd_fill_ok_next = rd_fill_ok_reg;
        rd_fwd_next     = 1'b0;
        fwd_data_next   = fwd_data_reg;
        rd_last_next    = rd_last_reg;
        emit            = arrival;
        emit_raw        = arr_byte;
        emit_last       = rd_last_reg;
        push            = 1'b0;
        push_item       = '{out_byte: 8'h00, status: 1'b1, last_of_run: 1'b1,
                            end_of_output: 1'b0};

        // Handle an accepted file byte
        if (accept) begin
            if (s_start_of_file) begin
                hdr_pos_next  = 4'd0;
                rejected_next = 1'b0;
                declared_next = '0;
                emitted_next  = '0;
                flags_next    = '0;
                pair_first_next = 8'h00;
                await_next    = 1'b0;
                wp_next       = INIT_PTR;
                fill_next     = '0;
            end
            if (!s_start_of_file && rejected_reg) begin
                // drop everything until the next file
            end else if (hdr_eff < HDR_LEN) begin
                if (hdr_eff < MAGIC_LEN && s_byte_value != magic_byte(hdr_eff)) begin
                    rejected_next = 1'b1;
                    push          = 1'b1;
                end else begin
                    if (hdr_eff >= LEN_FIELD_POS) begin
                        declared_next = declared_reg | lane_val[L-1:0];
                    end
                    hdr_pos_next = hdr_eff + 4'd1;
                end
            end else if (emitted_reg >= declared_reg) begin
                // length reached: drop body bytes
            end else if (await_reg) begin
                await_next   = 1'b0;
                rd_addr_next = ref_pos;
                rd_cnt_next  = (remaining < L'(ref_len)) ? remaining[CNT_W-1:0] : ref_len;
                state_next   = ST_COPY;
            end else if (!flags_reg[FLAG_VALID]) begin
                flags_next = {FLAG_MARK, s_byte_value};
            end else begin
                flags_next = flags_reg >> 1;
                if (flags_reg[0]) begin
                    emit      = 1'b1;
                    emit_raw  = s_byte_value;
                    emit_last = 1'b1;
                end else begin
                    pair_first_next = s_byte_value;
                    await_next      = 1'b1;
                end
            end
        end

        // Issue one window read per cycle while the copy runs and the queue has room
        case (state_reg)
            ST_COPY: begin
                if (issue) begin
                    rd_addr_next    = rd_addr_reg + W'(1);
                    rd_cnt_next     = rd_cnt_reg - CNT_W'(1);
                    rd_pending_next = 1'b1;
                    rd_fill_ok_next = {1'b0, rd_offset} < fill_reg;
                    rd_fwd_next     = arrival && (rd_addr_reg == wp_reg);
                    fwd_data_next   = arr_byte;
                    rd_last_next    = (rd_cnt_reg == CNT_W'(1));
                    if (rd_cnt_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_IDLE: begin
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Emit one decoded byte: window write, counters, queue push
        if (emit) begin
            push = 1'b1;
            push_item.out_byte      = (emitted_reg < L'(xor_len_reg)) ?
                                      (emit_raw ^ INVERT_MASK) : emit_raw;
            push_item.status        = 1'b0;
            push_item.last_of_run   = emit_last;
            push_item.end_of_output = (emitted_plus1 == declared_reg);
            emitted_next = emitted_plus1;
            wp_next      = wp_reg + W'(1);
            fill_next    = fill_reg[W] ? fill_reg : fill_reg + (W+1)'(1);
        end
    end

    assign win_we    = emit;
    assign win_wdata = emit_raw;

    // Two-entry output queue: output register plus skid entry
    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        if (pop || !out_valid_reg) begin
            if (pend_valid_reg) begin
                out_next        = pend_reg;
                out_valid_next  = 1'b1;
                pend_next       = push_item;
                pend_valid_next = push;
            end else begin
                out_next        = push_item;
                out_valid_next  = push;
                pend_valid_next = 1'b0;
            end
        end else if (push) begin
            pend_next       = push_item;
            pend_valid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            hdr_pos_reg    <= 4'd0;
            rejected_reg   <= 1'b0;
            declared_reg   <= '0;
            emitted_reg    <= '0;
            flags_reg      <= '0;
            pair_first_reg <= 8'h00;
            await_reg      <= 1'b0;
            wp_reg         <= INIT_PTR;
            fill_reg       <= '0;
            rd_cnt_reg     <= '0;
            rd_pending_reg <= 1'b0;
            rd_fwd_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            xor_len_reg    <= 8'd100;
        end else begin
            state_reg      <= state_next;
            hdr_pos_reg    <= hdr_pos_next;
            rejected_reg   <= rejected_next;
            declared_reg   <= declared_next;
            emitted_reg    <= emitted_next;
            flags_reg      <= flags_next;
            pair_first_reg <= pair_first_next;
            await_reg      <= await_next;
            wp_reg         <= wp_next;
            fill_reg       <= fill_next;
            rd_cnt_reg     <= rd_cnt_next;
            rd_pending_reg <= rd_pending_next;
            rd_fwd_reg     <= rd_fwd_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_wr_en) begin
                xor_len_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        rd_addr_reg    <= rd_addr_next;
        rd_fill_ok_reg <= rd_fill_ok_next;
        fwd_data_reg   <= fwd_data_next;
        rd_last_reg    <= rd_last_next;
        out_reg        <= out_next;
        pend_reg       <= pend_next;
    end

    szdd_ram #(
        .DATA_WIDTH (8),
        .DEPTH      (1 << WINDOW_BITS)
    ) u_window (
        .clk     (aclk),
        .wr_en   (win_we),
        .wr_addr (wp_reg),
        .wr_data (win_wdata),
        .rd_addr (rd_addr_reg),
        .rd_data (win_rdata)
    );

    assign m_valid         = out_valid_reg;
    assign m_out_byte      = out_reg.out_byte;
    assign m_status        = out_reg.status;
    assign m_last_of_run   = out_reg.last_of_run;
    assign m_end_of_output = out_reg.end_of_output;

    // Queue never receives a byte it has no room for
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && pend_valid_reg && out_valid_reg && !m_ready))
        else $error("output queue overflow");

    // A literal write never collides with a returning copy read
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(arrival && accept))
        else $error("request accepted while a copy read returns");

    // Fill count saturates at the window size
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_FULL)
        else $error("window fill count beyond window size");

    // A running copy always has reads left to issue
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COPY) |-> (rd_cnt_reg != '0))
        else $error("copy state with zero count");

    // A bad-header result carries a zero byte and no end mark
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_out_byte == 8'h00 && !m_end_of_output))
        else $error("malformed bad-header result");

endmodule

`default_nettype wire
